@@ design/pcfc_pkg.sv @@
// ----------------------------------------------------------------------------
// pcfc_pkg
// Shared types and constants for the parallel camera frame capture block.
// ----------------------------------------------------------------------------
package pcfc_pkg;

  localparam int unsigned ADDR_W    = 19;
  localparam int unsigned COL_W     = 10;
  localparam int unsigned ROW_W     = 9;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 10;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  typedef struct packed {
    logic              vsync;
    logic              href;
    logic              pclk;
    logic [BYTE_W-1:0] pixel_data;
  } pin_sample_t;

  typedef struct packed {
    logic [ADDR_W-1:0] write_address;
    logic [BYTE_W-1:0] write_byte;
    logic              frame_done;
  } result_t;

  typedef struct packed {
    logic [COL_W-1:0] width;
    logic [ROW_W-1:0] height;
  } frame_cfg_t;

endpackage

@@ design/pcfc_capture_core.sv @@
// ----------------------------------------------------------------------------
// pcfc_capture_core
// Frame/line tracking and byte capture; one pin sample per step.
// ----------------------------------------------------------------------------
module pcfc_capture_core
  import pcfc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 640,
  parameter int unsigned MAX_HEIGHT = 480
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  pin_sample_t sample,
  input  frame_cfg_t  cfg,
  output logic        produce,
  output result_t     result
);

  localparam logic [1:0] PH_WAIT_HIGH = 2'd0;
  localparam logic [1:0] PH_WAIT_LOW  = 2'd1;
  localparam logic [1:0] PH_CAPTURE   = 2'd2;

  logic [1:0]        phase, phase_next;
  logic              href_before, href_before_next;
  logic              pclk_before, pclk_before_next;
  logic              pending, pending_next;
  logic [COL_W-1:0]  column_count, column_count_next;
  logic [ROW_W-1:0]  row_count, row_count_next;
  logic [ADDR_W-1:0] row_base, row_base_next;

  logic [COL_W-1:0]  eff_width;
  logic [ROW_W-1:0]  eff_height;
  logic [COL_W-1:0]  col;
  logic              pclk_rise;

  // clamp to the build-time maxima
  assign eff_width  = ({1'b0, cfg.width} > (COL_W + 1)'(MAX_WIDTH)) ?
                      COL_W'(MAX_WIDTH) : cfg.width;
  assign eff_height = ({1'b0, cfg.height} > (ROW_W + 1)'(MAX_HEIGHT)) ?
                      ROW_W'(MAX_HEIGHT) : cfg.height;
  assign pclk_rise  = sample.pclk && !pclk_before;
  assign col        = (sample.href && !href_before) ? '0 : column_count;

  always_comb begin
    phase_next        = phase;
    href_before_next  = href_before;
    pclk_before_next  = pclk_before;
    pending_next      = pending;
    column_count_next = column_count;
    row_count_next    = row_count;
    row_base_next     = row_base;
    produce           = 1'b0;
    result            = '0;
    unique case (phase)
      PH_WAIT_HIGH: begin
        if (sample.vsync) begin
          phase_next = PH_WAIT_LOW;
        end
      end
      PH_CAPTURE: begin
        if (pending) begin
          // second byte of the pair: only waits for its pclk edge
          if (pclk_rise) begin
            pending_next = 1'b0;
          end
          pclk_before_next = sample.pclk;
        end else begin
          column_count_next = col;
          if (sample.href) begin
            if (pclk_rise) begin
              if (col < eff_width) begin
                produce              = 1'b1;
                result.write_address = row_base + ADDR_W'(col);
                result.write_byte    = sample.pixel_data;
                column_count_next    = col + 1'b1;
              end
              pending_next = 1'b1;
            end
            pclk_before_next = sample.pclk;
          end
          if (!sample.href && href_before) begin
            row_count_next = row_count + 1'b1;
            row_base_next  = row_base + ADDR_W'(eff_width);
            if (row_count_next >= eff_height) begin
              produce           = 1'b1;
              result.frame_done = 1'b1;
              phase_next        = PH_WAIT_HIGH;
            end
          end
          href_before_next = sample.href;
        end
      end
      default: begin
        // waiting for vsync low; arms the frame
        if (!sample.vsync) begin
          phase_next        = PH_CAPTURE;
          href_before_next  = 1'b0;
          pclk_before_next  = 1'b0;
          pending_next      = 1'b0;
          column_count_next = '0;
          row_count_next    = '0;
          row_base_next     = '0;
          if (eff_height == '0) begin
            produce           = 1'b1;
            result.frame_done = 1'b1;
            phase_next        = PH_WAIT_HIGH;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WAIT_HIGH;
      href_before  <= 1'b0;
      pclk_before  <= 1'b0;
      pending      <= 1'b0;
      column_count <= '0;
      row_count    <= '0;
      row_base     <= '0;
    end else if (step) begin
      phase        <= phase_next;
      href_before  <= href_before_next;
      pclk_before  <= pclk_before_next;
      pending      <= pending_next;
      column_count <= column_count_next;
      row_count    <= row_count_next;
      row_base     <= row_base_next;
    end
  end

`ifndef SYNTHESIS
  a_result_phase: assert property (@(posedge clk) disable iff (rst)
    step && produce |-> phase == PH_CAPTURE || phase == PH_WAIT_LOW)
    else $error("result outside an armed frame");

  a_done_rearms: assert property (@(posedge clk) disable iff (rst)
    step && produce && result.frame_done |=> phase == PH_WAIT_HIGH)
    else $error("frame done without return to vsync wait");

  a_write_skips: assert property (@(posedge clk) disable iff (rst)
    step && produce && !result.frame_done |=> pending)
    else $error("byte written without skipping its pair");
`endif

endmodule

@@ design/pcfc_out_buffer.sv @@
// ----------------------------------------------------------------------------
// pcfc_out_buffer
// Output register with a skid stage for the result word channel.
// ----------------------------------------------------------------------------
module pcfc_out_buffer
  import pcfc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_word,
  output logic    space,
  output logic    m_tvalid,
  input  logic    m_tready,
  output result_t m_word
);

  logic    skid_valid;
  result_t skid_word;
  logic    pop;

  assign pop   = m_tvalid && m_tready;
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        m_word     <= skid_word;
        skid_valid <= 1'b0;
      end
    end else if (push && (!m_tvalid || pop)) begin
      m_word   <= push_word;
      m_tvalid <= 1'b1;
    end else if (push) begin
      skid_word  <= push_word;
      skid_valid <= 1'b1;
    end else if (pop) begin
      m_tvalid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid word held with empty output register");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("word pushed into a full buffer");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    push && m_tvalid && !m_tready |=> skid_valid)
    else $error("stalled word not caught by skid stage");
`endif

endmodule

@@ design/parallel_camera_frame_capture.sv @@
// ----------------------------------------------------------------------------
// parallel_camera_frame_capture
// Captures bytes from sampled parallel camera pins into frame buffer writes.
// ----------------------------------------------------------------------------
// s_* : one pin sample per word (vsync, href, pclk, data bus), normally one
//       every clock. Each accepted word goes into an input register, is
//       processed once the buffer has space and may yield one result word.
// m_* : result words: a frame buffer write (address, byte) or, with tuser
//       set, an end-of-frame marker carrying address and byte of zero.
// cfg_*: register writes (frame width, frame height), always ready; apply
//       them while the block is idle. Unknown indexes are ignored.
// Path: sample into the input register, result into the output register.
// Throughput: one sample per clock while m_tready is high; the state update
//       for a sample is a single registered pass, so nothing iterates.
// Stalls: a stalled result sits in the output register and a second one in
//       the skid stage; s_tready drops only once the skid stage is full.
// Reset: synchronous; all state returns to waiting for vsync high, the
//       width and height registers return to 640 and 480, buffers empty.
// ----------------------------------------------------------------------------
module parallel_camera_frame_capture
  import pcfc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 640,
  parameter int unsigned MAX_HEIGHT = 480
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [0] vsync, [1] href, [2] pclk, [10:3] pixel_data, rest zero
  input  logic [S_TDATA_W-1:0] s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [18:0] write_address, [26:19] write_byte, rest zero
  output logic [M_TDATA_W-1:0] m_tdata,
  // [0] frame_done
  output logic                 m_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  frame_cfg_t  cfg;
  logic        in_valid;
  pin_sample_t in_sample;
  logic        advance;
  logic        space;
  logic        produce;
  result_t     result;
  result_t     m_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= COL_W'(640);
      cfg.height <= ROW_W'(480);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  cfg.width  <= cfg_data[COL_W-1:0];
        REG_FRAME_HEIGHT: cfg.height <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  assign advance  = in_valid && space;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_sample.vsync      <= s_tdata[0];
      in_sample.href       <= s_tdata[1];
      in_sample.pclk       <= s_tdata[2];
      in_sample.pixel_data <= s_tdata[10:3];
    end
  end

  pcfc_capture_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .sample  (in_sample),
    .cfg     (cfg),
    .produce (produce),
    .result  (result)
  );

  pcfc_out_buffer u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (advance && produce),
    .push_word (result),
    .space     (space),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_word    (m_word)
  );

  assign m_tdata = {{(M_TDATA_W - ADDR_W - BYTE_W){1'b0}},
                    m_word.write_byte, m_word.write_address};
  assign m_tuser = m_word.frame_done;

endmodule
